@@ rtl/consistent_hash_ring_router_top_defines.svh @@
// Assertion macros for the ring router.
`ifndef CONSISTENT_HASH_RING_ROUTER_TOP_DEFINES_SVH
`define CONSISTENT_HASH_RING_ROUTER_TOP_DEFINES_SVH
// Implication checked at each clock edge outside reset.
`define CHR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/chrr_pkg.sv @@
// ----------------------------------------------------------------------------
// chrr_pkg
// Shared types and codes of the ring router.
// ----------------------------------------------------------------------------
`default_nettype none
package chrr_pkg;
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_ROUTE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_POOL_EMPTY = 3'd1;
   localparam logic [2:0] ST_NO_HEALTHY = 3'd2;
   localparam logic [2:0] ST_COLLISION  = 3'd3;
   localparam logic [2:0] ST_RING_FULL  = 3'd4;

   localparam logic CSR_SERVICE_COUNT = 1'b0;
   localparam logic CSR_HEALTHY_MASK  = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] point_hash;
      logic [3:0]  point_owner;
      logic [63:0] key_hash;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] chosen_service;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;
endpackage
`default_nettype wire

@@ rtl/chrr_req_if.sv @@
// ----------------------------------------------------------------------------
// chrr_req_if
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none
interface chrr_req_if;
   logic valid;
   logic ready;
   chrr_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/chrr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// chrr_rsp_if
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
`default_nettype none
interface chrr_rsp_if;
   logic valid;
   logic ready;
   chrr_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/chrr_csr_if.sv @@
// ----------------------------------------------------------------------------
// chrr_csr_if
// Valid/ready register write channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface chrr_csr_if;
   logic valid;
   logic ready;
   chrr_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/consistent_hash_ring_router_top.sv @@
// Route: binary search for the first point above the key, then a wrapping walk to
// the first healthy owner. Insert: same search, a collision check on the entry
// before the position (none at position zero), entries shifted up one at a time
// (one-port ring memory), then the write. One word in flight; response register
// frees the request side once the word is taken. Synchronous active-high reset
// empties the ring and clears control registers; the memory itself is not swept.
`default_nettype none
`include "consistent_hash_ring_router_top_defines.svh"
module consistent_hash_ring_router_top #(
   parameter int RING_DEPTH   = 256,
   parameter int MAX_SERVICES = 16
) (
   input wire logic clock,
   input wire logic reset,
   chrr_req_if.sink req,
   chrr_rsp_if.source rsp,
   chrr_csr_if.sink csr
);
   localparam int AW = $clog2(RING_DEPTH);
   localparam int FW = $clog2(RING_DEPTH + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SRD    = 4'd1;  // issue search read
   localparam logic [3:0] S_SCMP   = 4'd2;  // compare mid entry
   localparam logic [3:0] S_CHK    = 4'd3;  // read entry before pos
   localparam logic [3:0] S_CHKW   = 4'd4;
   localparam logic [3:0] S_SHRD   = 4'd5;  // read entry to shift up
   localparam logic [3:0] S_SHWR   = 4'd6;
   localparam logic [3:0] S_INS    = 4'd7;
   localparam logic [3:0] S_WRD    = 4'd8;  // walk read
   localparam logic [3:0] S_WCHK   = 4'd9;
   localparam logic [3:0] S_RSP    = 4'd10;

   logic [3:0] state_ff, state_in;
   chrr_pkg::req_type cmd_ff, cmd_in;
   logic [FW-1:0] fill_ff, fill_in, lo_ff, lo_in, hi_ff, hi_in, cnt_ff, cnt_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [4:0]  svc_ff, svc_in;
   logic [15:0] mask_ff, mask_in;
   chrr_pkg::rsp_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [63:0] mem_hash [RING_DEPTH];
   logic [3:0]  mem_own [RING_DEPTH];
   logic [63:0] rd_hash_ff;
   logic [3:0]  rd_own_ff;
   logic [AW-1:0] addr;
   logic we;
   logic [63:0] wr_hash;
   logic [3:0] wr_own;

   logic [FW-1:0] mid;
   logic [63:0] probe;
   logic healthy;

   assign mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign probe = (cmd_ff.func == chrr_pkg::FUNC_INSERT) ? cmd_ff.point_hash
                                                          : cmd_ff.key_hash;
   always_comb begin
      healthy = 1'b0;
      if ({1'b0, rd_own_ff} < svc_ff && 32'(rd_own_ff) < MAX_SERVICES) begin
         healthy = mask_ff[rd_own_ff];
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = out_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_hash[addr] <= wr_hash;
         mem_own[addr]  <= wr_own;
      end
      rd_hash_ff <= mem_hash[addr];
      rd_own_ff  <= mem_own[addr];
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; fill_in = fill_ff;
      lo_in = lo_ff; hi_in = hi_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      svc_in = svc_ff; mask_in = mask_ff; out_in = out_ff;
      rsp_valid_in = rsp_valid_ff;
      addr = mid[AW-1:0]; we = 1'b0;
      wr_hash = rd_hash_ff; wr_own = rd_own_ff;
      if (csr.valid) begin
         if (csr.data.index == {1'b0, chrr_pkg::CSR_SERVICE_COUNT}) begin
            svc_in = csr.data.data[4:0];
         end else if (csr.data.index == {1'b0, chrr_pkg::CSR_HEALTHY_MASK}) begin
            mask_in = csr.data.data;
         end
      end
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               lo_in = '0; hi_in = fill_ff;
               out_in = '{status: chrr_pkg::ST_OK, chosen_service: 4'd0};
               state_in = S_RSP;
               if (req.data.func == chrr_pkg::FUNC_INSERT) begin
                  if (32'(fill_ff) >= RING_DEPTH) begin
                     out_in.status = chrr_pkg::ST_RING_FULL;
                  end else begin
                     state_in = S_SRD;
                  end
               end else if (req.data.func == chrr_pkg::FUNC_ROUTE) begin
                  if (svc_ff == '0 || fill_ff == '0) begin
                     out_in.status = chrr_pkg::ST_POOL_EMPTY;
                  end else begin
                     state_in = S_SRD;
                  end
               end else if (req.data.func == chrr_pkg::FUNC_CLEAR) begin
                  fill_in = '0;
               end
            end
         end
         S_SRD: begin
            if (lo_ff < hi_ff) begin
               state_in = S_SCMP;
            end else if (cmd_ff.func == chrr_pkg::FUNC_INSERT) begin
               state_in = (lo_ff == '0) ? S_SHRD : S_CHK;
               cnt_in = fill_ff;
            end else begin
               idx_in = (lo_ff >= fill_ff) ? '0 : lo_ff;
               cnt_in = '0;
               state_in = S_WRD;
            end
         end
         S_SCMP: begin
            if (rd_hash_ff <= probe) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_SRD;
         end
         S_CHK: begin
            addr = AW'(lo_ff - 1'b1);
            state_in = S_CHKW;
         end
         S_CHKW: begin
            if (rd_hash_ff == cmd_ff.point_hash) begin
               out_in.status = chrr_pkg::ST_COLLISION;
               state_in = S_RSP;
            end else begin
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            // cnt walks down from fill to pos, moving entry cnt-1 to cnt
            if (cnt_ff > lo_ff) begin
               addr = AW'(cnt_ff - 1'b1);
               state_in = S_SHWR;
            end else begin
               state_in = S_INS;
            end
         end
         S_SHWR: begin
            addr = cnt_ff[AW-1:0];
            we = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_INS: begin
            addr = lo_ff[AW-1:0];
            we = 1'b1;
            wr_hash = cmd_ff.point_hash;
            wr_own = cmd_ff.point_owner;
            fill_in = fill_ff + 1'b1;
            state_in = S_RSP;
         end
         S_WRD: begin
            addr = idx_ff[AW-1:0];
            state_in = S_WCHK;
         end
         S_WCHK: begin
            if (healthy) begin
               out_in.chosen_service = rd_own_ff;
               state_in = S_RSP;
            end else if (cnt_ff + 1'b1 >= fill_ff) begin
               out_in.status = chrr_pkg::ST_NO_HEALTHY;
               state_in = S_RSP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = (idx_ff + 1'b1 >= fill_ff) ? '0 : idx_ff + 1'b1;
               state_in = S_WRD;
            end
         end
         S_RSP: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         svc_ff <= '0;
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         svc_ff <= svc_in;
         mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; lo_ff <= lo_in; hi_ff <= hi_in;
      cnt_ff <= cnt_in; idx_ff <= idx_in; out_ff <= out_in;
   end

   `CHR_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, 32'(fill_ff) <= RING_DEPTH)
   `CHR_ASSERT_IMP(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE)
   `CHR_ASSERT_NEXT(a_one_word, clock, reset, req.valid && req.ready, !rsp_valid_ff)
   `CHR_ASSERT_IMP(a_ok_route, clock, reset,
      rsp_valid_ff && out_ff.status != chrr_pkg::ST_OK, out_ff.chosen_service == 4'd0)
endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Ring router testbench
// Drives insert, route, clear and unused request words into the ring router.
// A sorted ring model predicts responses no directed row fixes. Register writes
// are made only while the block is idle. Both handshake sides are throttled in
// several phases. A watchdog ends the run if the block stops moving words.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
   localparam int DEPTH = 256;
   localparam int NSVC = 16;
   localparam int SETTLE = 700;        // worst search plus a full walk or shift
   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] CSR_IDX_COUNT = {1'b0, chrr_pkg::CSR_SERVICE_COUNT};
   localparam logic [1:0] CSR_IDX_MASK = {1'b0, chrr_pkg::CSR_HEALTHY_MASK};
   localparam logic [1:0] CSR_IDX_SPARE2 = 2'd2;
   localparam logic [1:0] CSR_IDX_SPARE3 = 2'd3;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef struct {
      row_kind_type kind;
      chrr_pkg::req_type word;
      chrr_pkg::csr_type wr;
      bit fixed;
      chrr_pkg::rsp_type exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chrr_req_if req ();
   chrr_rsp_if rsp ();
   chrr_csr_if csr ();

   consistent_hash_ring_router_top dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ring model
   logic [63:0] ring_hash [DEPTH];
   logic [3:0] ring_owner [DEPTH];
   int unsigned ring_fill;
   logic [4:0] pool_size;
   logic [15:0] health_bits;

   chrr_pkg::rsp_type pending_rsp [$];
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit fixed_now = 1'b0;
   chrr_pkg::rsp_type fixed_rsp = '0;
   bit hold_go = 1'b0;
   int hold_left = 0;

   function automatic int unsigned first_above(logic [63:0] h);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = ring_fill;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (ring_hash[mid] <= h) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic bit owner_up(logic [3:0] o);
      return (o < pool_size) && (o < NSVC) && health_bits[o];
   endfunction

   // Apply one request word to the ring and return the response it earns.
   function automatic chrr_pkg::rsp_type ring_apply(chrr_pkg::req_type w);
      chrr_pkg::rsp_type r;
      int unsigned pos, idx;
      r = '0;
      r.status = chrr_pkg::ST_OK;
      case (w.func)
         chrr_pkg::FUNC_INSERT: begin
            if (ring_fill >= DEPTH) r.status = chrr_pkg::ST_RING_FULL;
            else begin
               pos = first_above(w.point_hash);
               if (pos > 0 && ring_hash[pos-1] == w.point_hash)
                  r.status = chrr_pkg::ST_COLLISION;
               else begin
                  for (int i = ring_fill; i > pos; i--) begin
                     ring_hash[i] = ring_hash[i-1];
                     ring_owner[i] = ring_owner[i-1];
                  end
                  ring_hash[pos] = w.point_hash;
                  ring_owner[pos] = w.point_owner;
                  ring_fill++;
               end
            end
         end
         chrr_pkg::FUNC_ROUTE: begin
            if (pool_size == 0 || ring_fill == 0) r.status = chrr_pkg::ST_POOL_EMPTY;
            else begin
               pos = first_above(w.key_hash);
               if (pos >= ring_fill) pos = 0;
               r.status = chrr_pkg::ST_NO_HEALTHY;
               for (int k = 0; k < ring_fill; k++) begin
                  idx = (pos + k) % ring_fill;
                  if (owner_up(ring_owner[idx])) begin
                     r.status = chrr_pkg::ST_OK;
                     r.chosen_service = ring_owner[idx];
                     break;
                  end
               end
            end
         end
         chrr_pkg::FUNC_CLEAR: ring_fill = 0;
         default: ;
      endcase
      return r;
   endfunction

   // predict, check, and keep the watchdog
   always @(posedge clock) begin
      chrr_pkg::rsp_type got, want, pred;
      if (!reset) begin
         if (csr.valid && csr.ready) begin
            if (csr.data.index == CSR_IDX_COUNT) pool_size = csr.data.data[4:0];
            else if (csr.data.index == CSR_IDX_MASK) health_bits = csr.data.data;
         end
         if (req.valid && req.ready) begin
            pred = ring_apply(req.data);
            pending_rsp.push_back(fixed_now ? fixed_rsp : pred);
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response status=%0d svc=%0d", got.status,
                           got.chosen_service);
            end else begin
               want = pending_rsp.pop_front();
               if (got.status !== want.status || got.chosen_service !== want.chosen_service)
               begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: exp status=%0d svc=%0d, got status=%0d svc=%0d",
                              want.status, want.chosen_service, got.status,
                              got.chosen_service);
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver throttle, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (hold_go && hold_left == 0 && $urandom_range(9) == 0) begin
         hold_left <= 2000;
         hold_go <= 1'b0;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_word(chrr_pkg::req_type w, bit fixed, chrr_pkg::rsp_type exp);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= w;
      fixed_now <= fixed;
      fixed_rsp <= exp;
      do @(posedge clock); while (!req.ready);
   endtask

   // hold until every response is in and the block has settled
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr.valid <= 1'b1;
      csr.data.index <= idx;
      csr.data.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_hash();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 30) return {56'h5A5A_0000_0000_00, 3'b0, 5'($urandom_range(31))};
      if (sel < 50 && ring_fill > 0) return ring_hash[$urandom_range(ring_fill - 1)];
      if (sel < 53) return '0;
      if (sel < 56) return '1;
      return rand64();
   endfunction

   function automatic chrr_pkg::req_type random_word();
      chrr_pkg::req_type w;
      int unsigned sel;
      w.point_hash = pick_hash();
      w.point_owner = 4'($urandom_range(15));
      w.key_hash = pick_hash();
      if ($urandom_range(3) == 0) w.key_hash = w.key_hash + 64'($urandom_range(2)) - 64'd1;
      sel = $urandom_range(99);
      if (sel < 46) w.func = chrr_pkg::FUNC_INSERT;
      else if (sel < 94) w.func = chrr_pkg::FUNC_ROUTE;
      else if (sel < 98) w.func = chrr_pkg::FUNC_CLEAR;
      else w.func = FUNC_UNUSED;
      return w;
   endfunction

   function automatic row_type w_row(logic [1:0] f, logic [63:0] ph, logic [3:0] po,
                                      logic [63:0] kh, bit fixed, logic [2:0] st);
      row_type r;
      r.kind = ROW_WORD;
      r.word = '{func: f, point_hash: ph, point_owner: po, key_hash: kh};
      r.wr = '0;
      r.fixed = fixed;
      r.exp = '{status: st, chosen_service: 4'd0};
      return r;
   endfunction

   function automatic row_type c_row(logic [1:0] idx, logic [15:0] value);
      row_type r;
      r.kind = ROW_CSR;
      r.word = '0;
      r.wr = '{index: idx, data: value};
      r.fixed = 1'b0;
      r.exp = '0;
      return r;
   endfunction

   row_type rows [$];
   int pct_send [4] = '{0, 51, 0, 23};
   int pct_recv [4] = '{0, 0, 51, 23};

   initial begin
      chrr_pkg::rsp_type none;
      chrr_pkg::req_type w;
      none = '0;
      ring_fill = 0;
      pool_size = '0;
      health_bits = '0;
      req.valid = 1'b0;
      req.data = '0;
      csr.valid = 1'b0;
      csr.data = '0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, '0, 1, chrr_pkg::ST_POOL_EMPTY));
      rows.push_back(w_row(chrr_pkg::FUNC_INSERT, '1, 4'd15, '0, 1, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_INSERT, '1, 4'd3, '1, 1, chrr_pkg::ST_COLLISION));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, '1, 1, chrr_pkg::ST_POOL_EMPTY));
      rows.push_back(c_row(CSR_IDX_COUNT, 16'd16));
      rows.push_back(c_row(CSR_IDX_MASK, 16'hFFFF));
      rows.push_back(w_row(chrr_pkg::FUNC_INSERT, '0, 4'd0, '0, 1, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000, 4'd7, '0, 1,
                           chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, '1, 0, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, '0, 0, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, 64'h8000_0000_0000_0000, 0,
                           chrr_pkg::ST_OK));
      rows.push_back(w_row(FUNC_UNUSED, '1, 4'd15, '1, 1, chrr_pkg::ST_OK));
      rows.push_back(c_row(CSR_IDX_MASK, 16'h0000));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, 64'h1234, 1,
                           chrr_pkg::ST_NO_HEALTHY));
      rows.push_back(c_row(CSR_IDX_SPARE2, 16'hFFFF));
      rows.push_back(c_row(CSR_IDX_SPARE3, 16'hFFFF));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, 64'h1234, 1,
                           chrr_pkg::ST_NO_HEALTHY));
      rows.push_back(c_row(CSR_IDX_MASK, 16'hFFFF));
      rows.push_back(c_row(CSR_IDX_COUNT, 16'd1));
      // owner beyond the pool is skipped
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, 64'h10, 0, chrr_pkg::ST_OK));
      rows.push_back(c_row(CSR_IDX_COUNT, 16'hFFFF));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, 64'h10, 0, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_CLEAR, '1, 4'd15, '1, 1, chrr_pkg::ST_OK));
      rows.push_back(w_row(chrr_pkg::FUNC_ROUTE, '0, 4'd0, '1, 1, chrr_pkg::ST_POOL_EMPTY));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            drain();
            write_reg(rows[i].wr.index, rows[i].wr.data);
         end else push_word(rows[i].word, rows[i].fixed, rows[i].exp);
      end
      drain();

      // fill the ring to the brim, then poke it while full
      write_reg(CSR_IDX_COUNT, 16'd16);
      write_reg(CSR_IDX_MASK, 16'($urandom));
      for (int i = 0; i < 262; i++) begin
         w = '0;
         w.func = chrr_pkg::FUNC_INSERT;
         w.point_hash = rand64();
         w.point_owner = 4'($urandom_range(15));
         if (i == 0) hold_go <= 1'b1;
         push_word(w, 0, none);
      end
      for (int i = 0; i < 8; i++) begin
         w = random_word();
         push_word(w, 0, none);
      end
      drain();
      w = '0;
      w.func = chrr_pkg::FUNC_CLEAR;
      push_word(w, 0, none);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct_send[ph];
         recv_stall_pct = pct_recv[ph];
         case (ph)
            0: write_reg(CSR_IDX_COUNT, 16'd16);
            1: write_reg(CSR_IDX_COUNT, 16'd0);
            default: write_reg(CSR_IDX_COUNT, 16'($urandom_range(31)));
         endcase
         write_reg(CSR_IDX_MASK, ph == 0 ? 16'hFFFF : 16'($urandom));
         for (int i = 0; i < 110; i++) begin
            // switch throttling off for the rest of each throttled phase
            if (i == 60 && ph != 0) begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            push_word(random_word(), 0, none);
         end
         drain();
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      drain();
      if (mismatches == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ consistent_hash_ring_router_top.f @@
+incdir+rtl
rtl/chrr_pkg.sv
rtl/chrr_req_if.sv
rtl/chrr_rsp_if.sv
rtl/chrr_csr_if.sv
rtl/consistent_hash_ring_router_top.sv
test/tb.sv
